@@ hw/rtl/sha256_pkg.sv @@
// shared types, constants and functions of the sha-256 block hashing engine
`timescale 1ns / 1ps

package sha256_pkg;

  localparam int unsigned WordW     = 32;
  localparam int unsigned ChainN    = 8;
  localparam int unsigned SchedN    = 16;
  localparam int unsigned RoundN    = 64;
  localparam int unsigned WcntW     = $clog2(SchedN);
  localparam int unsigned RcntW     = $clog2(RoundN);
  localparam int unsigned OcntW     = $clog2(ChainN) + 1;

  typedef logic [WordW-1:0] sha256_word_t;
  typedef logic [ChainN-1:0][WordW-1:0] sha256_chain_t;
  typedef logic [SchedN-1:0][WordW-1:0] sha256_sched_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FINISH
  } sha256_state_t;

  // controls from the sequencer to the schedule and round units
  typedef struct packed {
    logic in_shift;   // message word transfer, shift it into the window
    logic rnd_load;   // load working variables from the chaining state
    logic rnd_step;   // run one round and advance the schedule
  } sha256_ctl_t;

  // standard initial hash value
  localparam sha256_chain_t HASH_INIT = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  // round constants, entry 0 first
  localparam sha256_word_t K_ROUND [RoundN] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // upper-case sigma on a
  function automatic sha256_word_t big_sigma0(input sha256_word_t x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  // upper-case sigma on e
  function automatic sha256_word_t big_sigma1(input sha256_word_t x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  // lower-case sigma for w[t-15]
  function automatic sha256_word_t sml_sigma0(input sha256_word_t x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  // lower-case sigma for w[t-2]
  function automatic sha256_word_t sml_sigma1(input sha256_word_t x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

@@ hw/rtl/sha256_sched.sv @@
// message schedule: sixteen-word sliding window, one new word per round
`timescale 1ns / 1ps

module sha256_sched (
  input  logic                      clk,
  input  sha256_pkg::sha256_ctl_t   ctl,
  input  sha256_pkg::sha256_word_t  msg_word,
  output sha256_pkg::sha256_word_t  w_cur
);
  import sha256_pkg::*;

  sha256_sched_t win_r;
  sha256_sched_t win_nxt;
  sha256_word_t  w_new;

  // w[t+16] from the window that holds w[t] .. w[t+15]
  assign w_new = sml_sigma1(win_r[14]) + win_r[9] + sml_sigma0(win_r[1]) + win_r[0];

  // shift in either a message word or an expanded word
  always_comb begin
    win_nxt = win_r;
    if (ctl.in_shift) begin
      win_nxt = {msg_word, win_r[SchedN-1:1]};
    end else if (ctl.rnd_step) begin
      win_nxt = {w_new, win_r[SchedN-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    win_r <= win_nxt;
  end

  assign w_cur = win_r[0];

endmodule

@@ hw/rtl/sha256_round.sv @@
// compression round unit: working variables a..h, one round per cycle
`timescale 1ns / 1ps

module sha256_round (
  input  logic                      clk,
  input  sha256_pkg::sha256_ctl_t   ctl,
  input  sha256_pkg::sha256_chain_t chain,
  input  sha256_pkg::sha256_word_t  k_word,
  input  sha256_pkg::sha256_word_t  w_word,
  output sha256_pkg::sha256_chain_t vars
);
  import sha256_pkg::*;

  sha256_chain_t v_r;
  sha256_chain_t v_nxt;
  sha256_word_t  t1;
  sha256_word_t  t2;
  sha256_word_t  ch;
  sha256_word_t  maj;

  // round function, v_r[0] is a and v_r[7] is h
  assign ch  = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
  assign maj = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
  assign t1  = v_r[7] + big_sigma1(v_r[4]) + ch + k_word + w_word;
  assign t2  = big_sigma0(v_r[0]) + maj;

  always_comb begin
    v_nxt = v_r;
    if (ctl.rnd_load) begin
      v_nxt = chain;
    end else if (ctl.rnd_step) begin
      v_nxt[7] = v_r[6];
      v_nxt[6] = v_r[5];
      v_nxt[5] = v_r[4];
      v_nxt[4] = v_r[3] + t1;
      v_nxt[3] = v_r[2];
      v_nxt[2] = v_r[1];
      v_nxt[1] = v_r[0];
      v_nxt[0] = t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    v_r <= v_nxt;
  end

  assign vars = v_r;

endmodule

@@ hw/rtl/sha256_block_hash.sv @@
// sha-256 engine top level: sequencer, chaining state and digest output buffer
`timescale 1ns / 1ps

// Takes padded message words one per cycle while in_ready is high, sixteen per
// 512-bit block. The sixteenth word starts the compression, which runs its 64
// rounds one per cycle through the single round unit and then adds into the
// chaining state in the finish state; in_ready stays low from the sixteenth
// word until that add is done. With the final flag on a block's sixteenth word
// the sum goes instead to an output buffer and the chaining state is reset;
// the eight digest words drain on the out_ channel, first word first, while
// the next message is being taken; a later final block waits in its add cycle
// until that buffer is empty. A final flag on any other word is ignored.
module sha256_block_hash (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  sha256_pkg::sha256_word_t in_message_word,
  input  logic                     in_final_word,
  output logic                     out_valid,
  input  logic                     out_ready,
  output sha256_pkg::sha256_word_t out_digest_word,
  output logic                     out_digest_last
);
  import sha256_pkg::*;

  sha256_state_t    state_r;
  sha256_state_t    state_nxt;
  logic [WcntW-1:0] wcnt_r;
  logic [WcntW-1:0] wcnt_nxt;
  logic [RcntW-1:0] rcnt_r;
  logic [RcntW-1:0] rcnt_nxt;
  logic [OcntW-1:0] ocnt_r;
  logic [OcntW-1:0] ocnt_nxt;
  logic             fin_r;
  logic             fin_nxt;
  sha256_chain_t    chain_r;
  sha256_chain_t    chain_nxt;
  sha256_chain_t    dig_r;
  sha256_chain_t    dig_nxt;
  sha256_chain_t    vars;
  sha256_chain_t    sum;
  sha256_word_t     w_cur;
  sha256_ctl_t      ctl;
  logic             in_xfer;
  logic             out_xfer;
  logic             dig_load;

  assign in_ready = (state_r == ST_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  // unit controls
  assign ctl.in_shift = in_xfer;
  assign ctl.rnd_load = in_xfer && (wcnt_r == WcntW'(SchedN - 1));
  assign ctl.rnd_step = (state_r == ST_ROUND);

  sha256_sched u_sched (
    .clk      (clk),
    .ctl      (ctl),
    .msg_word (in_message_word),
    .w_cur    (w_cur)
  );

  sha256_round u_round (
    .clk    (clk),
    .ctl    (ctl),
    .chain  (chain_r),
    .k_word (K_ROUND[rcnt_r]),
    .w_word (w_cur),
    .vars   (vars)
  );

  // feed-forward add of the compressed block
  always_comb begin
    for (int i = 0; i < ChainN; i++) begin
      sum[i] = chain_r[i] + vars[i];
    end
  end

  // sequencer: next state and counters
  always_comb begin
    state_nxt = state_r;
    wcnt_nxt  = wcnt_r;
    rcnt_nxt  = rcnt_r;
    fin_nxt   = fin_r;
    chain_nxt = chain_r;
    dig_load  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          wcnt_nxt = wcnt_r + 1'b1;
          if (ctl.rnd_load) begin
            fin_nxt   = in_final_word;
            rcnt_nxt  = '0;
            state_nxt = ST_ROUND;
          end
        end
      end
      ST_ROUND: begin
        rcnt_nxt = rcnt_r + 1'b1;
        if (rcnt_r == RcntW'(RoundN - 1)) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!fin_r) begin
          chain_nxt = sum;
          state_nxt = ST_IDLE;
        end else if (ocnt_r == '0) begin
          dig_load  = 1'b1;
          chain_nxt = HASH_INIT;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // digest buffer drains one word per transfer
  always_comb begin
    dig_nxt  = dig_r;
    ocnt_nxt = ocnt_r;
    if (dig_load) begin
      dig_nxt  = sum;
      ocnt_nxt = OcntW'(ChainN);
    end else if (out_xfer) begin
      dig_nxt  = {WordW'(0), dig_r[ChainN-1:1]};
      ocnt_nxt = ocnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      wcnt_r  <= '0;
      rcnt_r  <= '0;
      ocnt_r  <= '0;
      fin_r   <= 1'b0;
      chain_r <= HASH_INIT;
    end else begin
      state_r <= state_nxt;
      wcnt_r  <= wcnt_nxt;
      rcnt_r  <= rcnt_nxt;
      ocnt_r  <= ocnt_nxt;
      fin_r   <= fin_nxt;
      chain_r <= chain_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dig_r <= dig_nxt;
  end

  assign out_valid       = (ocnt_r != '0);
  assign out_digest_word = dig_r[0];
  assign out_digest_last = (ocnt_r == OcntW'(1));

endmodule

@@ hw/rtl/sha256_block_hash_chk.sv @@
// port-level checker for the sha-256 engine, bound to the top level
`timescale 1ns / 1ps

module sha256_block_hash_chk (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input sha256_pkg::sha256_word_t out_digest_word,
  input logic                     out_digest_last
);
  import sha256_pkg::*;

  logic [WcntW-1:0]   icnt_r;
  logic [OcntW-2:0]   ocnt_r;
  logic               in_xfer;
  logic               out_xfer;
  logic               blk_end;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;
  assign blk_end  = in_xfer && (icnt_r == WcntW'(SchedN - 1));

  // word position within the block and within the digest
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      icnt_r <= '0;
      ocnt_r <= '0;
    end else begin
      if (in_xfer) begin
        icnt_r <= icnt_r + 1'b1;
      end
      if (out_xfer) begin
        ocnt_r <= ocnt_r + 1'b1;
      end
    end
  end

  // a stalled digest word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_digest_word)
      && $stable(out_digest_last))
    else $error("digest word changed while stalled");

  // a completed block stops intake at once
  a_blk_stall: assert property (@(posedge clk) disable iff (!rst_n)
    blk_end |=> !in_ready)
    else $error("word taken right after a block end");

  // intake is still off in the add cycle of the finish state
  a_blk_busy: assert property (@(posedge clk) disable iff (!rst_n)
    blk_end |-> ##65 !in_ready)
    else $error("word taken during compression");

  // last flag marks exactly the eighth digest word
  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer |-> (out_digest_last == (ocnt_r == (OcntW-1)'(ChainN - 1))))
    else $error("digest last flag misplaced");

  // the output is idle in the cycle after the last digest word is taken
  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer && out_digest_last |=> !out_valid)
    else $error("digest word right after the last one");

endmodule

bind sha256_block_hash sha256_block_hash_chk u_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_digest_word (out_digest_word),
  .out_digest_last (out_digest_last)
);
